// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the keypad countdown timer.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: expr");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: ante |=> cons");

`endif

// ===== rtl/kct_pkg.sv =====
// Package of the keypad countdown timer: payload structs, state struct, codes.
// No dependencies; imported by every module of the block.
package kct_pkg;

    localparam int unsigned SECONDS_W = 12;
    localparam int unsigned KEYS_W    = 3;
    localparam int unsigned NUM_ROWS  = 4;
    localparam int unsigned TICK_W    = 8;

    localparam logic [SECONDS_W-1:0] MAX_SECONDS       = 12'd3599;
    localparam logic [TICK_W-1:0]    TICK_DIVIDER_INIT = 8'd67;

    localparam logic [KEYS_W-1:0] KEY_PLUS   = 3'd4;
    localparam logic [KEYS_W-1:0] KEY_MINUS  = 3'd2;
    localparam logic [KEYS_W-1:0] KEY_ACTION = 3'd1;

    typedef enum logic [1:0] {
        MODE_SETTING  = 2'd0,
        MODE_COUNTING = 2'd1,
        MODE_STOPPED  = 2'd2
    } timer_mode_t;

    typedef struct packed {
        logic [2:0] row0_keys;
        logic [2:0] row1_keys;
        logic [2:0] row2_keys;
        logic [2:0] row3_keys;
    } in_item_t;

    typedef struct packed {
        logic [2:0] minute_tens;
        logic [3:0] minute_ones;
        logic [2:0] second_tens;
        logic [3:0] second_ones;
        logic       display_changed;
        logic [1:0] mode;
    } out_item_t;

    typedef struct packed {
        logic [2:0] minute_tens;
        logic [3:0] minute_ones;
        logic [2:0] second_tens;
        logic [3:0] second_ones;
    } digits_t;

    typedef struct packed {
        timer_mode_t                          mode;
        logic [SECONDS_W-1:0]                 seconds;
        logic [TICK_W-1:0]                    tick;
        logic [NUM_ROWS-1:0][KEYS_W-1:0]      prev_keys;
    } timer_state_t;

endpackage

// ===== rtl/kct_digits.sv =====
// Splits a seconds count (0..3599) into minute and second decimal digits.
// Depends on kct_pkg. Division by 60 and 10 uses reciprocal multiplies.
module kct_digits
    import kct_pkg::*;
(
    input  logic [SECONDS_W-1:0] seconds,
    output digits_t              digits
);

    logic [23:0] min_prod;
    logic [5:0]  minutes;
    logic [5:0]  secs;
    logic [13:0] mt_prod;
    logic [13:0] st_prod;
    logic [2:0]  min_tens;
    logic [2:0]  sec_tens;
    logic [11:0] min_times_60;

    always_comb
    begin
        // 2185 / 2^17 is close enough to 1/60 for every count up to 3599.
        min_prod     = 24'(seconds) * 24'd2185;
        minutes      = min_prod[22:17];
        min_times_60 = 12'(minutes) * 12'd60;
        secs         = 6'(seconds - min_times_60);

        // 205 / 2^11 stands in for 1/10 on values below 60.
        mt_prod  = 14'(minutes) * 14'd205;
        st_prod  = 14'(secs) * 14'd205;
        min_tens = mt_prod[13:11];
        sec_tens = st_prod[13:11];

        digits.minute_tens = min_tens;
        digits.minute_ones = 4'(minutes - 6'(min_tens) * 6'd10);
        digits.second_tens = sec_tens;
        digits.second_ones = 4'(secs - 6'(sec_tens) * 6'd10);
    end

endmodule

// ===== rtl/kct_step.sv =====
// Next-state logic of the timer for one keypad poll: mode, count, tick, key history.
// Depends on kct_pkg.
module kct_step
    import kct_pkg::*;
(
    input  timer_state_t      cur,
    input  in_item_t          keys,
    input  logic [TICK_W-1:0] divider,
    output timer_state_t      nxt
);

    logic [NUM_ROWS-1:0][KEYS_W-1:0] rows;
    logic [NUM_ROWS-1:0][KEYS_W-1:0] edge_keys;
    logic [TICK_W:0]                 tick_inc;
    logic [TICK_W-1:0]               tick_next;
    logic signed [13:0]              delta [NUM_ROWS];
    logic signed [13:0]              base;
    logic signed [13:0]              sum;
    logic [13:0]                     step_size [NUM_ROWS];
    timer_mode_t                     mode_next;

    assign rows = {keys.row3_keys, keys.row2_keys, keys.row1_keys, keys.row0_keys};

    assign step_size[0] = 14'd1;
    assign step_size[1] = 14'd10;
    assign step_size[2] = 14'd60;
    assign step_size[3] = 14'd600;

    always_comb
    begin
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            edge_keys[i] = (rows[i] != cur.prev_keys[i]) ? rows[i] : '0;
            if (edge_keys[i] == KEY_PLUS)
                delta[i] = $signed(step_size[i]);
            else if (edge_keys[i] == KEY_MINUS)
                delta[i] = -$signed(step_size[i]);
            else
                delta[i] = '0;
        end
        tick_inc  = {1'b0, cur.tick} + 9'd1;
        tick_next = (tick_inc > {1'b0, divider}) ? 8'd1 : tick_inc[TICK_W-1:0];
    end

    // Next mode.
    always_comb
    begin
        mode_next = cur.mode;
        unique case (cur.mode)
            MODE_SETTING:
            begin
                if (edge_keys[0] == KEY_ACTION)
                    mode_next = MODE_COUNTING;
            end
            MODE_COUNTING:
            begin
                if (cur.seconds == '0 || edge_keys[0] == KEY_ACTION)
                    mode_next = MODE_STOPPED;
            end
            default:
            begin
                if (edge_keys[2] == KEY_ACTION || edge_keys[1] == KEY_ACTION)
                    mode_next = MODE_SETTING;
                else if (edge_keys[0] == KEY_ACTION)
                    mode_next = MODE_COUNTING;
            end
        endcase
    end

    // Count, tick counter and recorded key codes.
    always_comb
    begin
        nxt.mode      = mode_next;
        nxt.tick      = tick_next;
        nxt.prev_keys = cur.prev_keys;
        base          = $signed({2'b00, cur.seconds});
        sum           = base;
        unique case (cur.mode)
            MODE_SETTING:
            begin
                nxt.prev_keys = rows;
                // A clear on row 2 drops the earlier rows; row 3 still applies.
                if (edge_keys[2] == KEY_ACTION)
                    base = '0;
                else
                    base = base + delta[0] + delta[1] + delta[2];
                sum = base + delta[3];
            end
            MODE_COUNTING:
            begin
                nxt.prev_keys[0] = rows[0];
                if (cur.seconds != '0 && tick_next == divider)
                    sum = base - 14'sd1;
            end
            default:
            begin
                nxt.prev_keys[0] = rows[0];
                nxt.prev_keys[1] = rows[1];
                nxt.prev_keys[2] = rows[2];
                if (edge_keys[2] == KEY_ACTION)
                    sum = '0;
            end
        endcase

        if (sum < 14'sd0)
            nxt.seconds = '0;
        else if (sum > $signed({2'b00, MAX_SECONDS}))
            nxt.seconds = MAX_SECONDS;
        else
            nxt.seconds = sum[SECONDS_W-1:0];
    end

endmodule

// ===== rtl/keypad_countdown_timer.sv =====
// Top level of the keypad countdown timer: handshake stages, state registers, assertions.
// Depends on kct_pkg, kct_digits, kct_step and assert_macros.svh.
//
// Usage: each input transaction on in_valid/in_ready is one keypad poll carrying the
// 3-bit code of all four rows. Every poll yields exactly one output transaction on
// out_valid/out_ready with the four displayed digits (the count as it stood before the
// poll), a flag that is set when those digits differ from the last ones shown, and the
// timer mode after the poll.
// The poll lands in an input register; once the output register is free, the step logic
// updates the timer state and loads the output register; out_valid rises with that load.
// The path from the input register through the step logic to the output register is
// the only per-poll work, so one poll is taken every cycle while the receiver keeps up.
// When the receiver stalls, the output register holds its transaction and the input
// register holds the pending poll; in_ready drops only once both are full.
// The divider register is written through cfg_wr_en/cfg_wr_data; the user must write it
// only while the block is idle, which the block itself does not enforce.
// Reset (rst_n low, asynchronous) empties both stages, clears the count, tick counter
// and key history, selects setting mode, marks nothing as shown and loads a divider of 67.
`include "assert_macros.svh"

module keypad_countdown_timer
    import kct_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);

    logic              in_valid_reg;
    in_item_t          in_data_reg;
    logic              out_valid_reg;
    out_item_t         out_data_reg;
    logic [TICK_W-1:0] divider_reg;
    timer_state_t      state_reg;
    timer_state_t      state_next;
    digits_t           shown_reg;
    logic              shown_valid_reg;
    digits_t           digits;
    logic              changed;
    logic              advance;
    logic              process;

    // The output register frees up when empty or being drained; the input stage
    // then moves its poll through the step logic in the same cycle.
    assign advance  = !out_valid_reg || out_ready;
    assign process  = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    kct_digits u_digits (
        .seconds (state_reg.seconds),
        .digits  (digits)
    );

    kct_step u_step (
        .cur     (state_reg),
        .keys    (in_data_reg),
        .divider (divider_reg),
        .nxt     (state_next)
    );

    assign changed = !shown_valid_reg || (digits != shown_reg);

    // Control registers of the two handshake stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_data_reg <= in_data;
        if (process)
        begin
            out_data_reg.minute_tens     <= digits.minute_tens;
            out_data_reg.minute_ones     <= digits.minute_ones;
            out_data_reg.second_tens     <= digits.second_tens;
            out_data_reg.second_ones     <= digits.second_ones;
            out_data_reg.display_changed <= changed;
            out_data_reg.mode            <= state_next.mode;
        end
    end

    // Timer state, display history and the divider register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= '{mode: MODE_SETTING, default: '0};
            shown_reg       <= '0;
            shown_valid_reg <= 1'b0;
            divider_reg     <= TICK_DIVIDER_INIT;
        end
        else
        begin
            if (cfg_wr_en)
                divider_reg <= cfg_wr_data;
            if (process)
            begin
                state_reg <= state_next;
                if (changed)
                begin
                    shown_reg       <= digits;
                    shown_valid_reg <= 1'b1;
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `ASSERT_ALWAYS(a_count_in_range, clk, rst_n, state_reg.seconds <= MAX_SECONDS)
    `ASSERT_NEXT(a_pending_poll_held, clk, rst_n, in_valid_reg && !advance, in_valid_reg)
    `ASSERT_NEXT(a_shown_after_poll, clk, rst_n, process, shown_valid_reg)
    `ASSERT_NEXT(a_tick_nonzero, clk, rst_n, process, state_reg.tick != 8'd0)

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for keypad_countdown_timer: keypad polls in, displayed digits out.
// Depends on kct_pkg and the RTL of the block; holds its own timer predictor and a
// score queue.
`timescale 1ns / 1ps

module tb_top;
    import kct_pkg::*;

    // Clock, reset and the ports of the block. Every input starts at a known value.
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    in_item_t   in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_item_t  out_data;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = 8'd0;

    // Polls waiting to be driven, and the display transactions that the predictor
    // expects back, oldest first.
    in_item_t  pending_polls[$];
    out_item_t expected_displays[$];
    out_item_t oldest_display;
    int        polls_queued = 0;
    int        mismatch_count = 0;

    // Idle and stall rates in percent, changed between phases of the run.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // Predictor state: a private copy of everything the block remembers.
    int          tick_limit = TICK_DIVIDER_INIT;
    int          timer_seconds = 0;
    timer_mode_t timer_mode = MODE_SETTING;
    int          tick_count = 0;
    logic [2:0]  last_row_code[4] = '{default: 3'd0};
    digits_t     shown_digits = '0;
    logic        digits_shown = 1'b0;

    keypad_countdown_timer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // A generous fixed budget; a correct run needs only a small fraction of it.
    initial
    begin
        #2_000_000;
        $display("tb_top failed");
        $finish;
    end

    // A row's code is a key press only when it differs from the code last recorded for
    // that row. The new code is recorded either way, so a row that the current mode
    // does not look at keeps its old record.
    function automatic logic [2:0] fresh_key(int row, logic [2:0] code);
        logic [2:0] key;
        key = 3'd0;
        if (code != last_row_code[row])
        begin
            key = code;
            last_row_code[row] = code;
        end
        return key;
    endfunction

    // Advances the predicted timer by one poll and returns the display transaction that
    // the block must produce for it.
    function automatic out_item_t advance_timer(in_item_t poll);
        digits_t    digits;
        out_item_t  display;
        logic [2:0] key;
        int         minutes;
        int         secs;
        minutes = timer_seconds / 60;
        secs = timer_seconds % 60;

        // The digits show the count as it stood before this poll.
        digits.minute_tens = 3'(minutes / 10);
        digits.minute_ones = 4'(minutes % 10);
        digits.second_tens = 3'(secs / 10);
        digits.second_ones = 4'(secs % 10);
        display.display_changed = !digits_shown || (digits != shown_digits);
        if (display.display_changed)
        begin
            shown_digits = digits;
            digits_shown = 1'b1;
        end

        // The tick counter runs 1..tick_limit, and also wraps when it has been left
        // above a divider that was lowered.
        tick_count = (tick_count + 1 > tick_limit) ? 1 : tick_count + 1;

        case (timer_mode)
            MODE_SETTING:
            begin
                // Rows act in order, so a clear on row 2 wipes what rows 0 and 1 did
                // but not what row 3 does afterwards.
                key = fresh_key(0, poll.row0_keys);
                if (key == KEY_PLUS) timer_seconds += 1;
                else if (key == KEY_MINUS) timer_seconds -= 1;
                else if (key == KEY_ACTION) timer_mode = MODE_COUNTING;
                key = fresh_key(1, poll.row1_keys);
                if (key == KEY_PLUS) timer_seconds += 10;
                else if (key == KEY_MINUS) timer_seconds -= 10;
                key = fresh_key(2, poll.row2_keys);
                if (key == KEY_PLUS) timer_seconds += 60;
                else if (key == KEY_MINUS) timer_seconds -= 60;
                else if (key == KEY_ACTION) timer_seconds = 0;
                key = fresh_key(3, poll.row3_keys);
                if (key == KEY_PLUS) timer_seconds += 600;
                else if (key == KEY_MINUS) timer_seconds -= 600;
            end
            MODE_COUNTING:
            begin
                // Zero is noticed one poll after it is reached. Only row 0 is looked at.
                if (timer_seconds == 0) timer_mode = MODE_STOPPED;
                else if (tick_count == tick_limit) timer_seconds -= 1;
                key = fresh_key(0, poll.row0_keys);
                if (key == KEY_ACTION) timer_mode = MODE_STOPPED;
            end
            default:
            begin
                // Stopped: row 3 is neither looked at nor recorded.
                key = fresh_key(0, poll.row0_keys);
                if (key == KEY_ACTION) timer_mode = MODE_COUNTING;
                key = fresh_key(1, poll.row1_keys);
                if (key == KEY_ACTION) timer_mode = MODE_SETTING;
                key = fresh_key(2, poll.row2_keys);
                if (key == KEY_ACTION)
                begin
                    timer_seconds = 0;
                    timer_mode = MODE_SETTING;
                end
            end
        endcase

        // The sum of all of this poll's adjustments is clamped once, at the end.
        if (timer_seconds < 0) timer_seconds = 0;
        else if (timer_seconds > MAX_SECONDS) timer_seconds = MAX_SECONDS;

        display.minute_tens = digits.minute_tens;
        display.minute_ones = digits.minute_ones;
        display.second_tens = digits.second_tens;
        display.second_ones = digits.second_ones;
        display.mode = timer_mode;
        return display;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // The case equality also catches X or Z on an output field.
    task automatic check_field(string name, logic [3:0] got, logic [3:0] want);
        if (got !== want)
            report_mismatch(name, got, want);
    endtask

    // Driver: a new poll is offered only when the slot is free, that is, when nothing is
    // offered or the offered transaction is being accepted at this edge. Otherwise valid
    // and payload hold still.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (pending_polls.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data <= pending_polls.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: ready is drawn afresh every cycle, independent of out_valid.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: predicts at every accepted poll and checks every accepted display
    // transaction against the oldest expectation. A poll accepted at the same edge is
    // always younger than the display leaving, so pushing first is harmless.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_displays.push_back(advance_timer(in_data));
            if (out_valid && out_ready)
            begin
                if (expected_displays.size() == 0)
                    report_mismatch("display transaction with none expected", out_data, 0);
                else
                begin
                    oldest_display = expected_displays.pop_front();
                    check_field("minute_tens", out_data.minute_tens, oldest_display.minute_tens);
                    check_field("minute_ones", out_data.minute_ones, oldest_display.minute_ones);
                    check_field("second_tens", out_data.second_tens, oldest_display.second_tens);
                    check_field("second_ones", out_data.second_ones, oldest_display.second_ones);
                    check_field("display_changed", out_data.display_changed,
                                oldest_display.display_changed);
                    check_field("mode", out_data.mode, oldest_display.mode);
                end
            end
        end
    end

    task automatic queue_poll(logic [2:0] r0, logic [2:0] r1, logic [2:0] r2,
                              logic [2:0] r3);
        in_item_t poll;
        poll.row0_keys = r0;
        poll.row1_keys = r1;
        poll.row2_keys = r2;
        poll.row3_keys = r3;
        pending_polls.push_back(poll);
        polls_queued++;
    endtask

    // Waits on falling edges, where every nonblocking update has settled, until no poll
    // is waiting or offered and every display has come back; then lets the two-stage
    // pipeline go quiet.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_polls.size() != 0 || in_valid || expected_displays.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // Divider write while the block is idle. The predictor takes the new value at once,
    // since nothing is in flight.
    task automatic write_divider(int value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= 8'(value);
        tick_limit = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // Directed opening: first display, all code bits high, clamping at both ends, clear
    // mixed with other rows, every mode change, and a start with the count at zero.
    task automatic queue_directed_polls();
        int i;
        queue_poll(3'd0, 3'd0, 3'd0, 3'd0);
        queue_poll(3'd7, 3'd7, 3'd7, 3'd7);
        // Six presses on every row at once push the count well past the top.
        for (i = 0; i < 6; i++)
        begin
            queue_poll(KEY_PLUS, KEY_PLUS, KEY_PLUS, KEY_PLUS);
            if (i % 2 == 0) queue_poll(3'd0, 3'd0, 3'd0, 3'd0);
            else queue_poll(3'd7, 3'd7, 3'd7, 3'd7);
        end
        // Minus ten, then clear, then plus ten minutes in a single poll.
        queue_poll(3'd7, KEY_MINUS, KEY_ACTION, KEY_PLUS);
        // Subtracting more than is left clamps at zero.
        queue_poll(3'd0, 3'd0, KEY_MINUS, KEY_MINUS);
        queue_poll(KEY_PLUS, KEY_PLUS, 3'd0, 3'd0);
        // Start, stop, resume, stop, clear from stopped.
        queue_poll(KEY_ACTION, 3'd0, 3'd0, 3'd0);
        queue_poll(3'd0, 3'd0, 3'd0, 3'd0);
        queue_poll(KEY_ACTION, 3'd0, 3'd0, 3'd0);
        queue_poll(3'd0, 3'd0, 3'd0, 3'd0);
        queue_poll(KEY_ACTION, 3'd0, 3'd0, 3'd0);
        queue_poll(3'd0, 3'd0, 3'd0, 3'd0);
        queue_poll(KEY_ACTION, 3'd0, 3'd0, 3'd0);
        queue_poll(3'd0, 3'd0, KEY_ACTION, 3'd0);
        // Start at zero stops on the next poll; then back to setting from stopped.
        queue_poll(KEY_ACTION, 3'd0, 3'd0, 3'd0);
        queue_poll(3'd0, 3'd0, 3'd0, 3'd0);
        queue_poll(3'd0, KEY_ACTION, 3'd0, 3'd0);
    endtask

    // Random polls, mostly press-and-release pairs and quiet stretches so the timer
    // really counts, plus short countdowns to zero when the divider is small, and some
    // polls with arbitrary codes on every row.
    task automatic queue_random_polls(int n_polls, int divider);
        int         first;
        int         pick;
        int         row;
        int         sec_presses;
        logic [2:0] code;
        logic [2:0] keys[4];
        first = polls_queued;
        while (polls_queued - first < n_polls)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                row = $urandom_range(3);
                pick = $urandom_range(9);
                code = (pick < 4) ? KEY_PLUS : (pick < 7) ? KEY_MINUS : KEY_ACTION;
                keys = '{default: 3'd0};
                keys[row] = code;
                queue_poll(keys[0], keys[1], keys[2], keys[3]);
                queue_poll(3'd0, 3'd0, 3'd0, 3'd0);
            end
            else if (pick < 65)
                repeat ($urandom_range(1, 30)) queue_poll(3'd0, 3'd0, 3'd0, 3'd0);
            else if (pick < 80 && divider <= 20)
            begin
                // Clear, set a few seconds, start, and wait past zero.
                sec_presses = $urandom_range(1, 4);
                queue_poll(3'd0, 3'd0, KEY_ACTION, 3'd0);
                queue_poll(3'd0, 3'd0, 3'd0, 3'd0);
                repeat (sec_presses)
                begin
                    queue_poll(KEY_PLUS, 3'd0, 3'd0, 3'd0);
                    queue_poll(3'd0, 3'd0, 3'd0, 3'd0);
                end
                queue_poll(KEY_ACTION, 3'd0, 3'd0, 3'd0);
                repeat ((sec_presses + 1) * divider + 2) queue_poll(3'd0, 3'd0, 3'd0, 3'd0);
            end
            else
                repeat ($urandom_range(1, 3))
                    queue_poll(3'($urandom_range(7)), 3'($urandom_range(7)),
                               3'($urandom_range(7)), 3'($urandom_range(7)));
        end
    endtask

    // Main sequence: eight phases, each with its own divider and handshake pressure.
    // The first phase runs on the reset divider; later phases write extremes and random
    // values, and a large divider is followed by a small one so the tick counter is
    // left above the new limit.
    initial
    begin
        int phase;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (phase = 0; phase < 8; phase++)
        begin
            if (phase > 0)
            begin
                wait_drained();
                case (phase)
                    1: write_divider(2);
                    2: write_divider(255);
                    3: write_divider($urandom_range(2, 20));
                    4: write_divider(3);
                    5: write_divider($urandom_range(2, 255));
                    6: write_divider(2);
                    default: write_divider($urandom_range(2, 10));
                endcase
            end

            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase

            if (phase == 0)
                queue_directed_polls();
            queue_random_polls(225, tick_limit);
        end

        wait_drained();
        repeat (6) @(posedge clk);
        if (expected_displays.size() != 0)
            report_mismatch("display transactions never produced", 0,
                            expected_displays.size());
        if (mismatch_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
